// ===== hdl/nearest_neighbor_downscaler_assert.svh =====
// Assertion macros shared by the checker.
`ifndef NEAREST_NEIGHBOR_DOWNSCALER_ASSERT_SVH
`define NEAREST_NEIGHBOR_DOWNSCALER_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define NND_ASSERT_IMP(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, quiet during reset.
`define NND_ASSERT_NXT_RST(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

// Next-cycle implication, always checked (used for reset behavior).
`define NND_ASSERT_NXT(lbl, clk, pre, post, msg) \
   lbl: assert property (@(posedge clk) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== hdl/nnd_pkg.sv =====
`timescale 1ns / 1ps

package nnd_pkg;

   localparam int MAX_DIMENSION = 1024;
   localparam int MAX_PLANES    = 1024;

   localparam int CFG_W       = 11;
   localparam int COORD_W     = 10;
   localparam int VALUE_W     = 64;
   localparam int CSR_INDEX_W = 3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SRC_WIDTH     = 3'd0,
      REG_SRC_HEIGHT    = 3'd1,
      REG_DST_WIDTH     = 3'd2,
      REG_DST_HEIGHT    = 3'd3,
      REG_CHANNEL_COUNT = 3'd4
   } csr_index_type;

   localparam logic [CFG_W-1:0] RESET_SRC_WIDTH     = CFG_W'(112);
   localparam logic [CFG_W-1:0] RESET_SRC_HEIGHT    = CFG_W'(112);
   localparam logic [CFG_W-1:0] RESET_DST_WIDTH     = CFG_W'(56);
   localparam logic [CFG_W-1:0] RESET_DST_HEIGHT    = CFG_W'(56);
   localparam logic [CFG_W-1:0] RESET_CHANNEL_COUNT = CFG_W'(64);

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [COORD_W-1:0]        column;
      logic [COORD_W-1:0]        row;
      logic [COORD_W-1:0]        channel;
      logic                      frame_last;
   } result_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Zero acts as one, anything above the limit acts as the limit.
   function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] hi);
      logic [CFG_W-1:0] r;
      if (v == '0) begin
         r = CFG_W'(1);
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// ===== hdl/nnd_front.sv =====
`timescale 1ns / 1ps

module nnd_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [nnd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [nnd_pkg::CFG_W-1:0]            csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [nnd_pkg::VALUE_W-1:0]   req_pixel_value,
   input  nnd_pkg::queue_status_type            queue_status,
   output logic                                 push,
   output nnd_pkg::result_type                  push_item
);
   import nnd_pkg::*;

   logic [CFG_W-1:0]   src_width_ff, src_height_ff, dst_width_ff, dst_height_ff;
   logic [CFG_W-1:0]   channel_count_ff;

   logic [COORD_W-1:0] in_column_ff, in_column_in;
   logic [COORD_W-1:0] in_row_ff, in_row_in;
   logic [COORD_W-1:0] in_plane_ff, in_plane_in;
   logic [CFG_W-1:0]   col_rem_ff, col_rem_in;
   logic [CFG_W-1:0]   row_rem_ff, row_rem_in;
   logic [COORD_W-1:0] next_col_ff, next_col_in;
   logic [COORD_W-1:0] next_row_ff, next_row_in;
   logic               row_taken_ff, row_taken_in;

   logic [CFG_W-1:0]   sw, sh, dw, dh, ch;
   logic               accept, col_sel, row_end, plane_end, frame_end;
   logic [CFG_W-1:0]   col_rem_step, row_rem_step;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff     <= RESET_SRC_WIDTH;
         src_height_ff    <= RESET_SRC_HEIGHT;
         dst_width_ff     <= RESET_DST_WIDTH;
         dst_height_ff    <= RESET_DST_HEIGHT;
         channel_count_ff <= RESET_CHANNEL_COUNT;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_SRC_WIDTH:     src_width_ff     <= csr_wdata;
            REG_SRC_HEIGHT:    src_height_ff    <= csr_wdata;
            REG_DST_WIDTH:     dst_width_ff     <= csr_wdata;
            REG_DST_HEIGHT:    dst_height_ff    <= csr_wdata;
            REG_CHANNEL_COUNT: channel_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      sw = clamp_size(src_width_ff, CFG_W'(MAX_DIMENSION));
      sh = clamp_size(src_height_ff, CFG_W'(MAX_DIMENSION));
      dw = clamp_size(dst_width_ff, sw);
      dh = clamp_size(dst_height_ff, sh);
      ch = clamp_size(channel_count_ff, CFG_W'(MAX_PLANES));
   end

   assign req_stall = queue_status.full;
   assign accept    = req_valid && !req_stall;

   // Remainder is d*S - x*D; a source coordinate is picked while it is below D.
   assign col_sel      = col_rem_ff < dw;
   assign col_rem_step = col_rem_ff + (col_sel ? sw : '0) - dw;
   assign row_rem_step = row_rem_ff + (row_taken_ff ? sh : '0) - dh;
   assign row_end      = ({1'b0, in_column_ff} + CFG_W'(1)) >= sw;
   assign plane_end    = ({1'b0, in_row_ff} + CFG_W'(1)) >= sh;
   assign frame_end    = ({1'b0, in_plane_ff} + CFG_W'(1)) >= ch;

   assign push = accept && col_sel && row_taken_ff;

   always_comb begin
      push_item.value      = req_pixel_value;
      push_item.column     = next_col_ff;
      push_item.row        = next_row_ff;
      push_item.channel    = in_plane_ff;
      push_item.frame_last = (({1'b0, in_plane_ff} + CFG_W'(1)) == ch) &&
                             (({1'b0, next_row_ff} + CFG_W'(1)) == dh) &&
                             (({1'b0, next_col_ff} + CFG_W'(1)) == dw);
   end

   always_comb begin
      in_column_in = in_column_ff;
      in_row_in    = in_row_ff;
      in_plane_in  = in_plane_ff;
      col_rem_in   = col_rem_ff;
      row_rem_in   = row_rem_ff;
      next_col_in  = next_col_ff;
      next_row_in  = next_row_ff;
      row_taken_in = row_taken_ff;
      if (accept) begin
         if (row_end) begin
            in_column_in = '0;
            col_rem_in   = '0;
            next_col_in  = '0;
            if (plane_end) begin
               in_row_in   = '0;
               row_rem_in  = '0;
               next_row_in = '0;
               in_plane_in = frame_end ? '0 : in_plane_ff + COORD_W'(1);
            end else begin
               in_row_in   = in_row_ff + COORD_W'(1);
               row_rem_in  = row_rem_step;
               next_row_in = next_row_ff + COORD_W'(row_taken_ff);
            end
            row_taken_in = row_rem_in < dh;
         end else begin
            in_column_in = in_column_ff + COORD_W'(1);
            col_rem_in   = col_rem_step;
            next_col_in  = next_col_ff + COORD_W'(col_sel);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_column_ff <= '0;
         in_row_ff    <= '0;
         in_plane_ff  <= '0;
         col_rem_ff   <= '0;
         row_rem_ff   <= '0;
         next_col_ff  <= '0;
         next_row_ff  <= '0;
         row_taken_ff <= 1'b1;
      end else begin
         in_column_ff <= in_column_in;
         in_row_ff    <= in_row_in;
         in_plane_ff  <= in_plane_in;
         col_rem_ff   <= col_rem_in;
         row_rem_ff   <= row_rem_in;
         next_col_ff  <= next_col_in;
         next_row_ff  <= next_row_in;
         row_taken_ff <= row_taken_in;
      end
   end

endmodule

// ===== hdl/nnd_queue.sv =====
`timescale 1ns / 1ps

module nnd_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  nnd_pkg::result_type       push_item,
   input  logic                      pop,
   output nnd_pkg::queue_status_type status,
   output nnd_pkg::result_type       head
);
   import nnd_pkg::*;

   result_type             entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign status.full  = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign status.empty = count_ff == '0;
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(do_push);
      rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(do_pop);
      count_in  = count_ff + QUEUE_CNT_W'(do_push) - QUEUE_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== hdl/nnd_back.sv =====
`timescale 1ns / 1ps

module nnd_back (
   input  logic                               clock,
   input  logic                               reset,
   input  nnd_pkg::queue_status_type          queue_status,
   input  nnd_pkg::result_type                head,
   output logic                               pop,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [nnd_pkg::VALUE_W-1:0] rsp_out_value,
   output logic [nnd_pkg::COORD_W-1:0]        rsp_out_column,
   output logic [nnd_pkg::COORD_W-1:0]        rsp_out_row,
   output logic [nnd_pkg::COORD_W-1:0]        rsp_out_channel,
   output logic                               rsp_frame_last
);
   import nnd_pkg::*;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_item_ff;
   logic       load;

   // Output register refills whenever it is empty or its beat is being taken.
   assign load = !rsp_valid_ff || !rsp_stall;
   assign pop  = load && !queue_status.empty;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = !queue_status.empty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_item_ff <= head;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_value   = rsp_item_ff.value;
   assign rsp_out_column  = rsp_item_ff.column;
   assign rsp_out_row     = rsp_item_ff.row;
   assign rsp_out_channel = rsp_item_ff.channel;
   assign rsp_frame_last  = rsp_item_ff.frame_last;

endmodule

// ===== hdl/nearest_neighbor_downscaler.sv =====
`timescale 1ns / 1ps
// Nearest-neighbor downscaler for planar multi-channel images.
// req_*: one source pixel per beat, plane by plane, rows in order, columns in order.
// rsp_*: one beat per picked pixel with its destination column, row and channel;
//   rsp_frame_last marks the final destination pixel of the last plane.
// csr_*: register writes (0 src_width, 1 src_height, 2 dst_width, 3 dst_height,
//   4 channel_count); write only while the block is idle. csr_ready is always high.
// Zero sizes act as one; sizes clamp to 1024 and the destination to the source.
// Throughput: one pixel per cycle in while req_stall is low, one result per cycle
//   out while rsp_stall is low. The front keeps per-axis remainder accumulators
//   (one add, compare, subtract per beat) and pushes picked pixels into a four-entry
//   queue; the back drains it into an output register that drives rsp_*.
//   A picked pixel enters the queue when accepted, then moves into that register.
// Stall: a stalled rsp beat holds; the queue absorbs up to four more picks and
//   req_stall rises only when it is full.
// Reset (synchronous): registers return to 112/112/56/56/64, the frame position
//   restarts at pixel zero and queued results are dropped.
module nearest_neighbor_downscaler (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [nnd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [nnd_pkg::CFG_W-1:0]          csr_wdata,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [nnd_pkg::VALUE_W-1:0] req_pixel_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [nnd_pkg::VALUE_W-1:0] rsp_out_value,
   output logic [nnd_pkg::COORD_W-1:0]        rsp_out_column,
   output logic [nnd_pkg::COORD_W-1:0]        rsp_out_row,
   output logic [nnd_pkg::COORD_W-1:0]        rsp_out_channel,
   output logic                               rsp_frame_last
);
   import nnd_pkg::*;

   queue_status_type queue_status;
   result_type       push_item, head;
   logic             push, pop;

   nnd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_value (req_pixel_value),
      .queue_status    (queue_status),
      .push            (push),
      .push_item       (push_item)
   );

   nnd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .status    (queue_status),
      .head      (head)
   );

   nnd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_status    (queue_status),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_value   (rsp_out_value),
      .rsp_out_column  (rsp_out_column),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_channel (rsp_out_channel),
      .rsp_frame_last  (rsp_frame_last)
   );

endmodule

// ===== hdl/nnd_checker.sv =====
`timescale 1ns / 1ps
`include "nearest_neighbor_downscaler_assert.svh"

module nnd_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               csr_valid,
   input logic                               csr_ready,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic signed [nnd_pkg::VALUE_W-1:0] rsp_out_value,
   input logic [nnd_pkg::COORD_W-1:0]        rsp_out_column,
   input logic [nnd_pkg::COORD_W-1:0]        rsp_out_row,
   input logic [nnd_pkg::COORD_W-1:0]        rsp_out_channel,
   input logic                               rsp_frame_last
);
   import nnd_pkg::*;

   logic               req_beat, rsp_beat, cfg_beat;
   logic [31:0]        pending_ff, pending_in;
   logic [COORD_W-1:0] last_col_ff, col_succ;
   logic               seen_ff;

   assign req_beat = req_valid && !req_stall;
   assign rsp_beat = rsp_valid && !rsp_stall;
   assign cfg_beat = csr_valid && csr_ready;
   assign col_succ = last_col_ff + COORD_W'(1);

   // Inputs accepted minus results delivered; a result needs an earlier input.
   always_comb begin
      pending_in = pending_ff + 32'(req_beat) - 32'(rsp_beat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         seen_ff    <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         if (rsp_beat) begin
            seen_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_beat) begin
         last_col_ff <= rsp_out_column;
      end
   end

   `NND_ASSERT_NXT(a_reset_quiet, clock, reset, !rsp_valid && !req_stall, "outputs not idle after reset")

   `NND_ASSERT_NXT_RST(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_value) && $stable(rsp_out_column) && $stable(rsp_out_row) && $stable(rsp_out_channel) && $stable(rsp_frame_last), "stalled rsp beat changed")

   `NND_ASSERT_IMP(a_no_invented, clock, reset, rsp_beat, pending_ff != '0, "result delivered without a pending input")

   `NND_ASSERT_IMP(a_column_order, clock, reset, rsp_beat && seen_ff && !cfg_beat, rsp_out_column == col_succ || rsp_out_column == '0, "destination column skipped")

endmodule

bind nearest_neighbor_downscaler nnd_checker u_checker (.*);

// ===== tb/sv/nearest_neighbor_downscaler_checker.sv =====
`timescale 1ns / 1ps

module nearest_neighbor_downscaler_checker
   import nnd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CFG_W-1:0]           csr_wdata,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic signed [VALUE_W-1:0]  req_pixel_value,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic signed [VALUE_W-1:0]  rsp_out_value,
   input  logic [COORD_W-1:0]         rsp_out_column,
   input  logic [COORD_W-1:0]         rsp_out_row,
   input  logic [COORD_W-1:0]         rsp_out_channel,
   input  logic                       rsp_frame_last,
   output int                         mismatch_count,
   output int                         expected_pending
);

   logic [CFG_W-1:0]   cfg_src_w, cfg_src_h, cfg_dst_w, cfg_dst_h, cfg_planes;
   logic [COORD_W-1:0] col_pos, row_pos, plane_pos, dest_col, dest_row;
   logic [CFG_W-1:0]   col_residue, row_residue;
   logic               row_selected;

   result_type picks_due [$];
   result_type beat_seen, beat_due;
   int errors = 0;
   int waiting = 0;

   assign mismatch_count   = errors;
   assign expected_pending = waiting;

   function automatic logic [CFG_W-1:0] effective(input logic [CFG_W-1:0] raw,
                                                  input logic [CFG_W-1:0] ceiling);
      return (raw == '0) ? CFG_W'(1) : ((raw > ceiling) ? ceiling : raw);
   endfunction

   // Advances the source position by one pixel; returns 1 when the pixel is kept.
   function automatic bit select_pixel(input logic signed [VALUE_W-1:0] pixel,
                                       output result_type picked);
      logic [CFG_W-1:0] sw, sh, dw, dh, planes;
      logic [CFG_W:0]   sum;
      bit               col_hit, hit;
      sw     = effective(cfg_src_w, CFG_W'(MAX_DIMENSION));
      sh     = effective(cfg_src_h, CFG_W'(MAX_DIMENSION));
      dw     = effective(cfg_dst_w, sw);
      dh     = effective(cfg_dst_h, sh);
      planes = effective(cfg_planes, CFG_W'(MAX_PLANES));
      col_hit = col_residue < dw;
      hit     = col_hit && row_selected;

      picked            = '0;
      picked.value      = pixel;
      picked.column     = dest_col;
      picked.row        = dest_row;
      picked.channel    = plane_pos;
      picked.frame_last = (plane_pos + 1 == planes) && (dest_row + 1 == dh) &&
                          (dest_col + 1 == dw);

      sum = col_residue;
      if (col_hit) begin
         sum      = sum + sw;
         dest_col = dest_col + 1'b1;
      end
      col_residue = CFG_W'(sum - dw);

      if (col_pos + 1 >= sw) begin
         col_pos     = '0;
         col_residue = '0;
         dest_col    = '0;
         sum = row_residue;
         if (row_selected) begin
            sum      = sum + sh;
            dest_row = dest_row + 1'b1;
         end
         row_residue = CFG_W'(sum - dh);
         if (row_pos + 1 >= sh) begin
            row_pos     = '0;
            row_residue = '0;
            dest_row    = '0;
            plane_pos   = (plane_pos + 1 >= planes) ? '0 : plane_pos + 1'b1;
         end else begin
            row_pos = row_pos + 1'b1;
         end
         row_selected = row_residue < dh;
      end else begin
         col_pos = col_pos + 1'b1;
      end
      return hit;
   endfunction

   task automatic compare_field(input string label, input logic [VALUE_W-1:0] due,
                                input logic [VALUE_W-1:0] seen);
      if (due !== seen) begin
         errors++;
         $display("%0t: %s expected %0h actual %0h", $time, label, due, seen);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_src_w    = RESET_SRC_WIDTH;
         cfg_src_h    = RESET_SRC_HEIGHT;
         cfg_dst_w    = RESET_DST_WIDTH;
         cfg_dst_h    = RESET_DST_HEIGHT;
         cfg_planes   = RESET_CHANNEL_COUNT;
         col_pos      = '0;
         row_pos      = '0;
         plane_pos    = '0;
         dest_col     = '0;
         dest_row     = '0;
         col_residue  = '0;
         row_residue  = '0;
         row_selected = 1'b1;
         picks_due.delete();
         waiting <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_SRC_WIDTH:     cfg_src_w  = csr_wdata;
               REG_SRC_HEIGHT:    cfg_src_h  = csr_wdata;
               REG_DST_WIDTH:     cfg_dst_w  = csr_wdata;
               REG_DST_HEIGHT:    cfg_dst_h  = csr_wdata;
               REG_CHANNEL_COUNT: cfg_planes = csr_wdata;
               default: ;
            endcase
         end

         if (rsp_valid && !rsp_stall) begin
            beat_seen.value      = rsp_out_value;
            beat_seen.column     = rsp_out_column;
            beat_seen.row        = rsp_out_row;
            beat_seen.channel    = rsp_out_channel;
            beat_seen.frame_last = rsp_frame_last;
            if (picks_due.size() == 0) begin
               errors++;
               $display({"%0t: beat expected none actual value %0h",
                         " col %0d row %0d ch %0d last %0b"},
                        $time, beat_seen.value, beat_seen.column, beat_seen.row,
                        beat_seen.channel, beat_seen.frame_last);
            end else begin
               beat_due = picks_due.pop_front();
               compare_field("value", beat_due.value, beat_seen.value);
               compare_field("column", beat_due.column, beat_seen.column);
               compare_field("row", beat_due.row, beat_seen.row);
               compare_field("channel", beat_due.channel, beat_seen.channel);
               compare_field("frame_last", beat_due.frame_last, beat_seen.frame_last);
            end
         end

         if (req_valid && !req_stall) begin
            if (select_pixel(req_pixel_value, beat_due))
               picks_due.push_back(beat_due);
         end
         waiting <= picks_due.size();
      end
   end

endmodule

// ===== tb/sv/nearest_neighbor_downscaler_test.sv =====
`timescale 1ns / 1ps

module nearest_neighbor_downscaler_test;
   import nnd_pkg::*;

   localparam int CLOCK_PERIOD   = 20;
   localparam int RESET_CYCLES   = 5;
   localparam int RANDOM_ITEMS   = 470;
   localparam int SWEEP_ITEMS    = 220;
   localparam int MAX_WAIT       = 6;
   localparam int SETTLE_CYCLES  = 4;
   localparam int DRAIN_LIMIT    = 10000;
   localparam int RUN_LIMIT_NS   = 20_000_000;
   localparam int FRAME_CAP      = 240;
   localparam int FRAGMENT_MAX   = 40;
   localparam int REG_COUNT      = REG_CHANNEL_COUNT + 1;
   localparam logic [CSR_INDEX_W-1:0] SPARE_FIRST = CSR_INDEX_W'(REG_COUNT);
   localparam logic [CSR_INDEX_W-1:0] SPARE_LAST  = '1;
   localparam logic [CFG_W-1:0]       CFG_ALL_ONES = '1;
   localparam logic [CFG_W-1:0]       SWEEP_DST    = CFG_W'(5);
   localparam logic signed [VALUE_W-1:0] PIXEL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic signed [VALUE_W-1:0] PIXEL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_W-1:0]    csr_index = '0;
   logic [CFG_W-1:0]          csr_wdata = '0;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [VALUE_W-1:0] req_pixel_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [VALUE_W-1:0] rsp_out_value;
   logic [COORD_W-1:0]        rsp_out_column;
   logic [COORD_W-1:0]        rsp_out_row;
   logic [COORD_W-1:0]        rsp_out_channel;
   logic                      rsp_frame_last;
   int                        mismatch_count;
   int                        expected_pending;

   bit          req_gaps_on = 1'b0;
   bit          rsp_stalls_on = 1'b0;
   int          rsp_hold = 0;
   int          rsp_draw;
   int unsigned reg_shadow [REG_COUNT];

   nearest_neighbor_downscaler u_top (.*);

   nearest_neighbor_downscaler_checker u_checker (.*);

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // After each accepted beat, draw a random rsp stall that holds off the next one while rsp_stalls_on is set.
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         rsp_draw = rsp_stalls_on ? $urandom_range(MAX_WAIT, 0) : 0;
         rsp_hold  <= rsp_draw;
         rsp_stall <= (rsp_draw != 0);
      end else if (rsp_hold != 0) begin
         rsp_hold  <= rsp_hold - 1;
         rsp_stall <= (rsp_hold > 1);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CFG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      if (index < REG_COUNT)
         reg_shadow[index] = 32'(value);
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic send_pixel(input logic signed [VALUE_W-1:0] value);
      int gap;
      gap = req_gaps_on ? $urandom_range(MAX_WAIT, 0) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel_value <= value;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic signed [VALUE_W-1:0] random_pixel();
      logic signed [VALUE_W-1:0] v;
      case ($urandom_range(7, 0))
         0:       v = PIXEL_MIN;
         1:       v = PIXEL_MAX;
         2:       v = '1;
         3:       v = '0;
         default: v = {$urandom, $urandom};
      endcase
      return v;
   endfunction

   task automatic run_pixels(input int count);
      csr_valid <= 1'b0;
      repeat (count) send_pixel(random_pixel());
      req_valid <= 1'b0;
   endtask

   // Wait until every picked pixel has drained, then pick new idling for the next phase.
   task automatic settle();
      @(posedge clock);
      while (expected_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      req_gaps_on   <= ($urandom_range(3, 0) != 0);
      rsp_stalls_on <= ($urandom_range(3, 0) != 0);
   endtask

   function automatic logic [CFG_W-1:0] draw_size(input logic [CSR_INDEX_W-1:0] index);
      int common_max;
      case (index)
         REG_CHANNEL_COUNT:             common_max = 3;
         REG_DST_WIDTH, REG_DST_HEIGHT: common_max = 8;
         default:                       common_max = 6;
      endcase
      case ($urandom_range(15, 0))
         0:       return '0;
         1:       return CFG_W'($urandom);
         default: return CFG_W'($urandom_range(common_max, 1));
      endcase
   endfunction

   function automatic int used_size(input int unsigned raw, input int ceiling);
      return (raw == 0) ? 1 : ((raw > ceiling) ? ceiling : raw);
   endfunction

   function automatic int frame_pixels();
      return used_size(reg_shadow[REG_SRC_WIDTH], MAX_DIMENSION) *
             used_size(reg_shadow[REG_SRC_HEIGHT], MAX_DIMENSION) *
             used_size(reg_shadow[REG_CHANNEL_COUNT], MAX_PLANES);
   endfunction

   initial begin
      logic signed [VALUE_W-1:0] corner_pixels [6];
      int frame;
      int count;
      int random_sent;
      int drain_cycles;

      corner_pixels = '{PIXEL_MIN, 64'h5555_5555_5555_5555, PIXEL_MAX, '0, '1,
                        64'hAAAA_AAAA_AAAA_AAAA};
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset geometry halves each axis: every other column of row 0 comes out.
      foreach (corner_pixels[i]) send_pixel(corner_pixels[i]);
      req_valid <= 1'b0;

      // Mid-row change: the column count is already past the new width,
      // destination wider than source clamps, spare index is ignored.
      settle();
      write_reg(REG_SRC_WIDTH, 5);
      write_reg(REG_SRC_HEIGHT, 3);
      write_reg(REG_DST_WIDTH, 9);
      write_reg(REG_DST_HEIGHT, 2);
      write_reg(REG_CHANNEL_COUNT, 2);
      write_reg(SPARE_LAST, CFG_ALL_ONES);
      run_pixels(10);

      // All zero acts as 1x1x1: the first pixel realigns the position and every later pixel ends a frame.
      settle();
      write_reg(REG_SRC_WIDTH, 0);
      write_reg(REG_SRC_HEIGHT, 0);
      write_reg(REG_DST_WIDTH, 0);
      write_reg(REG_DST_HEIGHT, 0);
      write_reg(REG_CHANNEL_COUNT, 0);
      run_pixels(2);

      // Sizes above the limit: every plane up to the limit, then a long row and a
      // long column whose second pick lands where the clamped source size puts it.
      settle();
      write_reg(REG_CHANNEL_COUNT, CFG_ALL_ONES);
      run_pixels(MAX_PLANES);
      settle();
      write_reg(REG_CHANNEL_COUNT, 1);
      write_reg(REG_SRC_WIDTH, CFG_ALL_ONES);
      write_reg(REG_DST_WIDTH, SWEEP_DST);
      run_pixels(SWEEP_ITEMS);
      settle();
      write_reg(REG_SRC_WIDTH, 1);
      write_reg(REG_DST_WIDTH, 1);
      write_reg(REG_SRC_HEIGHT, CFG_ALL_ONES);
      write_reg(REG_DST_HEIGHT, SWEEP_DST);
      run_pixels(SWEEP_ITEMS);

      // Random geometries: mostly whole frames, some fragments that leave a frame open.
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         settle();
         for (int r = REG_SRC_WIDTH; r < REG_COUNT; r++) begin
            if ($urandom_range(1, 0) != 0)
               write_reg(CSR_INDEX_W'(r), draw_size(CSR_INDEX_W'(r)));
         end
         if ($urandom_range(7, 0) == 0)
            write_reg(CSR_INDEX_W'($urandom_range(SPARE_LAST, SPARE_FIRST)),
                      CFG_W'($urandom));
         frame = frame_pixels();
         if (frame <= FRAME_CAP && $urandom_range(3, 0) != 0)
            count = frame;
         else
            count = $urandom_range(FRAGMENT_MAX, 1);
         run_pixels(count);
         random_sent += count;
      end

      @(posedge clock);
      drain_cycles = 0;
      while (expected_pending != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_pending == 0) begin
         $display("nearest_neighbor_downscaler: match");
      end else begin
         $display("nearest_neighbor_downscaler: mismatch");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("nearest_neighbor_downscaler: mismatch");
      $finish;
   end

endmodule
